### src/tgarle_pkg.sv
package tgarle_pkg;

  localparam int MAX_DIM_LOG2 = 11;
  localparam int MIN_WIDTH_LOG2 = 2;
  localparam int DIM_W  = MAX_DIM_LOG2;
  localparam int PIX_W  = 2 * MAX_DIM_LOG2 + 1;
  localparam int ADDR_W = 2 * MAX_DIM_LOG2;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [DIM_W:0]    room_t;
  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [7:0]        count_t;
  typedef logic [3:0]        log2_t;

  typedef enum logic [1:0] {
    REG_RLE_ENABLE      = 2'd0,
    REG_BYTES_PER_PIXEL = 2'd1,
    REG_WIDTH_LOG2      = 2'd2,
    REG_HEIGHT_LOG2     = 2'd3
  } reg_index_t;

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } colour_t;

  // One span step: the next piece of a run, clipped to the current row.
  typedef struct packed {
    logic   live;
    logic   last;
    logic   done;
    addr_t  address;
    count_t count;
    pix_t   pixel_next;
    count_t left_next;
  } span_t;

  localparam logic [7:0] CH_FULL  = 8'hff;
  localparam logic [7:0] CH_EMPTY = 8'h00;

endpackage

### src/tgarle_span.sv
module tgarle_span (
  input  tgarle_pkg::pix_t   pixel_index,
  input  tgarle_pkg::count_t left,
  input  tgarle_pkg::log2_t  wl,
  input  tgarle_pkg::log2_t  hl,
  output tgarle_pkg::span_t  span
);

  tgarle_pkg::dim_t   wmask;
  tgarle_pkg::dim_t   hmask;
  tgarle_pkg::dim_t   col;
  tgarle_pkg::dim_t   row;
  tgarle_pkg::dim_t   flipped;
  tgarle_pkg::pix_t   shifted;
  tgarle_pkg::room_t  room;
  tgarle_pkg::pix_t   total;
  logic [4:0]         area_log2;

  assign area_log2 = {1'b0, wl} + {1'b0, hl};
  assign total     = tgarle_pkg::pix_t'(1) << area_log2;
  assign wmask     = (tgarle_pkg::dim_t'(1) << wl) - tgarle_pkg::dim_t'(1);
  assign hmask     = (tgarle_pkg::dim_t'(1) << hl) - tgarle_pkg::dim_t'(1);
  assign shifted   = pixel_index >> wl;
  assign col       = pixel_index[tgarle_pkg::DIM_W-1:0] & wmask;
  assign row       = shifted[tgarle_pkg::DIM_W-1:0] & hmask;
  assign flipped   = hmask & ~row;
  // room left in this row, up to a full row
  assign room      = (tgarle_pkg::room_t'(1) << wl) - tgarle_pkg::room_t'(col);

  always_comb begin
    span.live    = (left != '0) && (pixel_index < total);
    span.address = (tgarle_pkg::addr_t'(flipped) << wl) | tgarle_pkg::addr_t'(col);
    span.count   = (tgarle_pkg::room_t'(left) < room) ? left : room[7:0];
    span.pixel_next = pixel_index + tgarle_pkg::pix_t'(span.count);
    span.left_next  = left - span.count;
    span.done    = span.pixel_next >= total;
    span.last    = (span.left_next == '0) || span.done;
  end

endmodule

### src/tga_rle_pixel_decoder.sv
// TGA pixel-data decoder: bytes in, RGBA spans out at bottom-up addresses.
// A byte that completes a pixel moves the decoder to its emit state, from which
// its first span is loaded into the output register; further spans of a repeat
// run follow one per cycle while the output is not stalled. Bytes that finish no
// pixel leave the decoder idle; no new byte is taken while a pixel's spans are
// emitted or it is dropped past the image end. Repeat runs crossing rows give one span per row.
// Reset (rst, synchronous) restores register defaults and decoder state.
module tga_rle_pixel_decoder (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic [0:0]  s_tuser,   // [0] frame_start
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [21:0] span_address, [29:22] span_count,
                                 // [37:30] red, [45:38] green, [53:46] blue,
                                 // [61:54] alpha, [63:62] zero
  output logic [0:0]  m_tuser,   // [0] image_done
  output logic        m_tlast,   // last_of_run
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);

  // configuration registers, kept raw; clamping happens on use
  logic       rle_enable;
  logic [2:0] bytes_per_pixel;
  tgarle_pkg::log2_t width_log2;
  tgarle_pkg::log2_t height_log2;

  // decoder state
  tgarle_pkg::state_t state, state_next;
  logic               awaiting_header, awaiting_header_next;
  logic               packet_is_repeat, packet_is_repeat_next;
  tgarle_pkg::count_t packet_pixels_left, packet_pixels_left_next;
  logic [1:0]         byte_in_pixel, byte_in_pixel_next;
  logic [23:0]        partial_pixel, partial_pixel_next;
  tgarle_pkg::pix_t   pixel_index, pixel_index_next;
  logic               image_finished, image_finished_next;

  // run being emitted
  tgarle_pkg::count_t  run_left, run_left_next;
  tgarle_pkg::colour_t run_colour, run_colour_next;

  tgarle_pkg::log2_t  wl_eff;
  tgarle_pkg::log2_t  hl_eff;
  tgarle_pkg::span_t  span;

  logic               accept;
  logic               frame_clr;
  logic               cur_await;
  logic               cur_rep;
  tgarle_pkg::count_t cur_left;
  logic [1:0]         cur_bip;
  logic [23:0]        cur_part;
  logic [23:0]        part_new;
  logic               bpp4;
  logic               pix_done;
  logic               is_magenta;
  logic               out_load;

  assign accept    = s_tvalid && s_tready;
  assign s_tready  = (state == tgarle_pkg::ST_IDLE);
  assign frame_clr = s_tuser[0];
  assign bpp4      = bytes_per_pixel[2];

  always_comb begin
    wl_eff = width_log2;
    if (width_log2 < tgarle_pkg::log2_t'(tgarle_pkg::MIN_WIDTH_LOG2)) begin
      wl_eff = tgarle_pkg::log2_t'(tgarle_pkg::MIN_WIDTH_LOG2);
    end else if (width_log2 > tgarle_pkg::log2_t'(tgarle_pkg::MAX_DIM_LOG2)) begin
      wl_eff = tgarle_pkg::log2_t'(tgarle_pkg::MAX_DIM_LOG2);
    end
    hl_eff = height_log2;
    if (height_log2 > tgarle_pkg::log2_t'(tgarle_pkg::MAX_DIM_LOG2)) begin
      hl_eff = tgarle_pkg::log2_t'(tgarle_pkg::MAX_DIM_LOG2);
    end
  end

  // state as seen by this byte, after an optional frame restart
  assign cur_await = frame_clr | awaiting_header;
  assign cur_rep   = frame_clr ? 1'b0 : packet_is_repeat;
  assign cur_left  = frame_clr ? '0 : packet_pixels_left;
  assign cur_bip   = frame_clr ? '0 : byte_in_pixel;
  assign cur_part  = frame_clr ? '0 : partial_pixel;

  // B, G, R lanes; the alpha byte of BGRA is not stored
  always_comb begin
    part_new = cur_part;
    case (cur_bip)
      2'd0:    part_new[7:0]   = s_tdata;
      2'd1:    part_new[15:8]  = s_tdata;
      2'd2:    part_new[23:16] = s_tdata;
      default: part_new = cur_part;
    endcase
  end

  assign pix_done   = bpp4 ? (cur_bip == 2'd3) : (cur_bip >= 2'd2);
  assign is_magenta = (part_new[23:16] == tgarle_pkg::CH_FULL) &&
                      (part_new[15:8] == tgarle_pkg::CH_EMPTY) &&
                      (part_new[7:0] == tgarle_pkg::CH_FULL);

  // shared span step: one row-clipped span per cycle while the output is not stalled
  tgarle_span u_span (
    .pixel_index (pixel_index),
    .left        (run_left),
    .wl          (wl_eff),
    .hl          (hl_eff),
    .span        (span)
  );

  always_comb begin
    state_next              = state;
    awaiting_header_next    = awaiting_header;
    packet_is_repeat_next   = packet_is_repeat;
    packet_pixels_left_next = packet_pixels_left;
    byte_in_pixel_next      = byte_in_pixel;
    partial_pixel_next      = partial_pixel;
    pixel_index_next        = pixel_index;
    image_finished_next     = image_finished;
    run_left_next           = run_left;
    run_colour_next         = run_colour;
    out_load                = 1'b0;

    case (state)
      tgarle_pkg::ST_IDLE: begin
        if (accept) begin
          awaiting_header_next    = cur_await;
          packet_is_repeat_next   = cur_rep;
          packet_pixels_left_next = cur_left;
          byte_in_pixel_next      = cur_bip;
          partial_pixel_next      = cur_part;
          if (frame_clr) begin
            pixel_index_next    = '0;
            image_finished_next = 1'b0;
          end
          if (rle_enable && (cur_await || cur_left == '0)) begin
            // packet header: raw of H+1 pixels, or repeat of H-127
            packet_is_repeat_next   = s_tdata[7];
            packet_pixels_left_next = s_tdata[7] ? (s_tdata - 8'd127) : (s_tdata + 8'd1);
            awaiting_header_next    = 1'b0;
            byte_in_pixel_next      = '0;
          end else begin
            partial_pixel_next = part_new;
            if (!pix_done) begin
              byte_in_pixel_next = cur_bip + 2'd1;
            end else begin
              byte_in_pixel_next = '0;
              run_colour_next.red   = part_new[23:16];
              run_colour_next.green = part_new[15:8];
              run_colour_next.blue  = part_new[7:0];
              run_colour_next.alpha = bpp4 ? s_tdata :
                                      (is_magenta ? tgarle_pkg::CH_EMPTY : tgarle_pkg::CH_FULL);
              if (!rle_enable) begin
                run_left_next = 8'd1;
              end else if (cur_rep) begin
                run_left_next           = cur_left;
                packet_pixels_left_next = '0;
                awaiting_header_next    = 1'b1;
              end else begin
                run_left_next           = 8'd1;
                packet_pixels_left_next = cur_left - 8'd1;
                awaiting_header_next    = (cur_left == 8'd1);
              end
              state_next = tgarle_pkg::ST_EMIT;
            end
          end
        end
      end

      tgarle_pkg::ST_EMIT: begin
        if (!span.live || image_finished) begin
          // pixel lands past the image end: dropped
          state_next = tgarle_pkg::ST_IDLE;
        end else if (!m_tvalid || m_tready) begin
          out_load         = 1'b1;
          pixel_index_next = span.pixel_next;
          run_left_next    = span.left_next;
          if (span.done) begin
            image_finished_next = 1'b1;
          end
          if (span.last) begin
            state_next = tgarle_pkg::ST_IDLE;
          end
        end
      end

      default: state_next = tgarle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rle_enable      <= 1'b1;
      bytes_per_pixel <= 3'd4;
      width_log2      <= 4'd8;
      height_log2     <= 4'd8;
    end else if (cfg_we) begin
      case (cfg_index)
        tgarle_pkg::REG_RLE_ENABLE:      rle_enable      <= cfg_data[0];
        tgarle_pkg::REG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        tgarle_pkg::REG_WIDTH_LOG2:      width_log2      <= cfg_data;
        tgarle_pkg::REG_HEIGHT_LOG2:     height_log2     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= tgarle_pkg::ST_IDLE;
      awaiting_header    <= 1'b1;
      packet_is_repeat   <= 1'b0;
      packet_pixels_left <= '0;
      byte_in_pixel      <= '0;
      partial_pixel      <= '0;
      pixel_index        <= '0;
      image_finished     <= 1'b0;
      run_left           <= '0;
    end else begin
      state              <= state_next;
      awaiting_header    <= awaiting_header_next;
      packet_is_repeat   <= packet_is_repeat_next;
      packet_pixels_left <= packet_pixels_left_next;
      byte_in_pixel      <= byte_in_pixel_next;
      partial_pixel      <= partial_pixel_next;
      pixel_index        <= pixel_index_next;
      image_finished     <= image_finished_next;
      run_left           <= run_left_next;
    end
  end

  // colour of the run: payload only
  always_ff @(posedge clk) begin
    run_colour <= run_colour_next;
  end

  // output register: holds a span until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {2'b00, run_colour.alpha, run_colour.blue, run_colour.green,
                  run_colour.red, span.count, span.address};
      m_tuser <= span.done;
      m_tlast <= span.last;
    end
  end

endmodule

### src/tgarle_checker.sv
module tgarle_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [0:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  // stalled span holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled span changed");

  // span length within one packet's reach
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[29:22] != 8'd0) && (m_tdata[29:22] <= 8'd128))
    else $error("span count out of range");

  // final pixel of the image ends the byte's spans
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tlast)
    else $error("image end without last of run");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (.*);
